// ===== hdl/utc_datetime_to_epoch_seconds_core_defines.svh =====
// Assertion macros shared by the timestamp converter RTL.
`ifndef UTC_DATETIME_TO_EPOCH_SECONDS_CORE_DEFINES_SVH
`define UTC_DATETIME_TO_EPOCH_SECONDS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTCEP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTCEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/utcep_pkg.sv =====
// Types, constants and calendar tables for the timestamp converter.
package utcep_pkg;

  typedef logic [7:0]         char_t;
  typedef logic signed [38:0] secs_t;

  // Text layout.
  localparam logic [4:0] TEXT_LEN    = 5'd19;
  localparam logic [4:0] POS_SAT     = 5'd20;
  localparam logic [4:0] POS_DASH_1  = 5'd4;
  localparam logic [4:0] POS_DASH_2  = 5'd7;
  localparam logic [4:0] POS_SPACE   = 5'd10;
  localparam logic [4:0] POS_COLON_1 = 5'd13;
  localparam logic [4:0] POS_COLON_2 = 5'd16;
  localparam logic [4:0] POS_YEAR_3  = 5'd2;
  localparam logic [4:0] POS_YEAR_4  = 5'd3;

  // Character codes.
  localparam char_t ASCII_DASH  = 8'h2D;
  localparam char_t ASCII_SPACE = 8'h20;
  localparam char_t ASCII_COLON = 8'h3A;
  localparam char_t ASCII_ZERO  = 8'h30;
  localparam char_t ASCII_NINE  = 8'h39;

  // Calendar arithmetic.
  localparam int EPOCH_SHIFT  = 719468;
  localparam int YEAR_DAYS    = 365;
  localparam int DAY_SECONDS  = 86400;
  localparam int HOUR_SECONDS = 3600;
  localparam int MIN_SECONDS  = 60;
  // x / 25 == (x * 5243) >> 17 for every x below 43000.
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int          RECIP_SHIFT = 17;

  localparam secs_t EPOCH_MIN = -39'sd62135596800;
  localparam secs_t EPOCH_MAX = 39'sd253402300799;

  // Days from March 1 to the first day of month m, in a year that starts in March.
  function automatic logic [8:0] month_offset(input logic [6:0] m);
    logic [8:0] r;
    case (m)
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Month length in a common year.
  function automatic logic [4:0] month_days(input logic [6:0] m);
    logic [4:0] r;
    case (m) inside
      7'd4, 7'd6, 7'd9, 7'd11: r = 5'd30;
      7'd2:                    r = 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/utcep_in_if.sv =====
// Character stream channel: one text character per beat.
interface utcep_in_if;
  import utcep_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

// ===== hdl/utcep_out_if.sv =====
// Result channel: one converted timestamp per beat.
interface utcep_out_if;
  import utcep_pkg::*;

  logic  valid;
  logic  ready;
  logic  valid_res;
  secs_t epoch_seconds;

  modport source (output valid, output valid_res, output epoch_seconds, input ready);
  modport sink (input valid, input valid_res, input epoch_seconds, output ready);
endinterface

// ===== hdl/utc_datetime_to_epoch_seconds_core.sv =====
// Streaming converter from "YYYY-MM-DD HH:MM:SS" text to signed Unix seconds.
//
// The block reads a timestamp one ASCII character per input beat, with is_last
// set on the final character, and returns one result beat per timestamp. The
// text must be exactly 19 characters with '-' at positions 4 and 7, a space at
// position 10, ':' at positions 13 and 16 and decimal digits everywhere else;
// the fields must name a real Gregorian date and time of day (year 1 or later).
// A good timestamp gives valid_res = 1 and the seconds since 1970-01-01 00:00:00
// UTC; anything else gives valid_res = 0 and epoch_seconds = 0. One character is
// taken every cycle while in_s.ready is high, and the next timestamp may start
// in the cycle right after a last character. The result of a timestamp passes
// through the three conversion stages (range checks and constant products, the
// day-count sum, the multiply by 86400) and then the result register. The
// conversion stages collapse bubbles, so in_s.ready falls only when the result
// port is stalled and every stage holds a timestamp.
module utc_datetime_to_epoch_seconds_core (
  input  logic         clk,
  input  logic         rst_n,
  utcep_in_if.sink     in_s,
  utcep_out_if.source  out_m
);
  import utcep_pkg::*;

  // ---------------------------------------------------------------------------
  // Character intake: field accumulators and the format check.
  // ---------------------------------------------------------------------------
  logic [4:0]  pos_r,  pos_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  mon_r,  mon_nxt;
  logic [6:0]  day_r,  day_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  min_r,  min_nxt;
  logic [6:0]  sec_r,  sec_nxt;
  logic        bad_r,  bad_nxt;
  // The last two year digits were both zero (year divisible by 100).
  logic        ylz_r,  ylz_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic        in_acc;
  logic        rdy1;

  function automatic logic [13:0] acc14(input logic [13:0] v, input logic [3:0] d);
    return 14'({v, 3'b000} + {v, 1'b0} + {10'd0, d});
  endfunction

  function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
    return 7'({v, 3'b000} + {v, 1'b0} + {3'd0, d});
  endfunction

  assign in_acc   = in_s.valid && in_s.ready;
  assign is_digit = (in_s.char_code >= ASCII_ZERO) && (in_s.char_code <= ASCII_NINE);
  assign digit    = in_s.char_code[3:0];

  // State after the current character is taken.
  always_comb begin
    year_nxt = year_r;
    mon_nxt  = mon_r;
    day_nxt  = day_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    bad_nxt  = bad_r;
    ylz_nxt  = ylz_r;
    if (pos_r >= TEXT_LEN) begin
      bad_nxt = 1'b1;
    end else begin
      unique case (pos_r) inside
        POS_DASH_1, POS_DASH_2: begin
          if (in_s.char_code != ASCII_DASH) bad_nxt = 1'b1;
        end
        POS_SPACE: begin
          if (in_s.char_code != ASCII_SPACE) bad_nxt = 1'b1;
        end
        POS_COLON_1, POS_COLON_2: begin
          if (in_s.char_code != ASCII_COLON) bad_nxt = 1'b1;
        end
        default: begin
          if (!is_digit) begin
            bad_nxt = 1'b1;
          end else if (pos_r < POS_DASH_1) begin
            year_nxt = acc14(year_r, digit);
            if (pos_r == POS_YEAR_3) ylz_nxt = (digit == 4'd0);
            if (pos_r == POS_YEAR_4) ylz_nxt = ylz_r && (digit == 4'd0);
          end else if (pos_r < POS_DASH_2) begin
            mon_nxt = acc7(mon_r, digit);
          end else if (pos_r < POS_SPACE) begin
            day_nxt = acc7(day_r, digit);
          end else if (pos_r < POS_COLON_1) begin
            hour_nxt = acc7(hour_r, digit);
          end else if (pos_r < POS_COLON_2) begin
            min_nxt = acc7(min_r, digit);
          end else begin
            sec_nxt = acc7(sec_r, digit);
          end
        end
      endcase
    end
    pos_nxt = (pos_r >= TEXT_LEN) ? POS_SAT : 5'(pos_r + 5'd1);
  end

  // A last character hands the fields to the conversion stages and clears
  // the accumulators for the next timestamp.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      year_r <= '0;
      mon_r  <= '0;
      day_r  <= '0;
      hour_r <= '0;
      min_r  <= '0;
      sec_r  <= '0;
      bad_r  <= 1'b0;
      ylz_r  <= 1'b0;
    end else if (in_acc) begin
      if (in_s.is_last) begin
        pos_r  <= '0;
        year_r <= '0;
        mon_r  <= '0;
        day_r  <= '0;
        hour_r <= '0;
        min_r  <= '0;
        sec_r  <= '0;
        bad_r  <= 1'b0;
        ylz_r  <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        year_r <= year_nxt;
        mon_r  <= mon_nxt;
        day_r  <= day_nxt;
        hour_r <= hour_nxt;
        min_r  <= min_nxt;
        sec_r  <= sec_nxt;
        bad_r  <= bad_nxt;
        ylz_r  <= ylz_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: each stage moves when the one after it is empty or moving.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_v_r;
  logic rdy2, rdy3, rdy_o;

  assign rdy_o = !out_v_r || out_m.ready;
  assign rdy3  = !v3_r || rdy_o;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;

  assign in_s.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r    <= in_acc && in_s.is_last;
      if (rdy2)  v2_r    <= v1_r;
      if (rdy3)  v3_r    <= v2_r;
      if (rdy_o) out_v_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: range checks and the constant products.
  // The day count uses days(yy) = 365*yy + yy/4 - yy/100 + yy/400, where yy is
  // the year shifted so that the year starts in March.
  // ---------------------------------------------------------------------------
  logic [13:0] y1_r;
  logic [6:0]  m1_r, d1_r, h1_r, mi1_r, s1_r;
  logic        bad1_r, ylz1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      y1_r   <= year_nxt;
      m1_r   <= mon_nxt;
      d1_r   <= day_nxt;
      h1_r   <= hour_nxt;
      mi1_r  <= min_nxt;
      s1_r   <= sec_nxt;
      bad1_r <= bad_nxt || (pos_nxt != TEXT_LEN);
      ylz1_r <= ylz_nxt;
    end
  end

  logic        early;
  logic [13:0] yy1;
  logic        leap1;
  logic [4:0]  maxd1;
  logic        ok1;
  logic [21:0] yy365_1;
  logic [24:0] p100_1;
  logic [22:0] p400_1;
  logic [16:0] tod1;

  always_comb begin
    early = (m1_r <= 7'd2);
    yy1   = y1_r - {13'd0, early};
    // Divisible by 400 is divisible by 100 and by 16.
    leap1 = (y1_r[1:0] == 2'd0) && (!ylz1_r || (y1_r[3:0] == 4'd0));
    maxd1 = 5'(month_days(m1_r) + {4'd0, (m1_r == 7'd2) && leap1});
    ok1   = !bad1_r && (y1_r != 14'd0) && (m1_r >= 7'd1) && (m1_r <= 7'd12) &&
            (d1_r >= 7'd1) && (d1_r <= {2'd0, maxd1}) && (h1_r <= 7'd23) &&
            (mi1_r <= 7'd59) && (s1_r <= 7'd59);
    yy365_1 = {8'd0, yy1} * 22'(YEAR_DAYS);
    p100_1  = {13'd0, yy1[13:2]} * {12'd0, RECIP_25};
    p400_1  = {13'd0, yy1[13:4]} * {10'd0, RECIP_25};
    tod1    = 17'({12'd0, h1_r[4:0]} * 17'(HOUR_SECONDS)) +
              17'({11'd0, mi1_r[5:0]} * 17'(MIN_SECONDS)) +
              {11'd0, s1_r[5:0]};
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sum of the day-count terms.
  // ---------------------------------------------------------------------------
  logic        ok2_r;
  logic [21:0] yy365_2_r;
  logic [11:0] yy4_2_r;
  logic [24:0] p100_2_r;
  logic [22:0] p400_2_r;
  logic [8:0]  moff2_r;
  logic [4:0]  dd2_r;
  logic [16:0] tod2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ok2_r     <= ok1;
      yy365_2_r <= yy365_1;
      yy4_2_r   <= yy1[13:2];
      p100_2_r  <= p100_1;
      p400_2_r  <= p400_1;
      moff2_r   <= month_offset(m1_r);
      dd2_r     <= d1_r[4:0];
      tod2_r    <= tod1;
    end
  end

  logic [23:0] days2;

  // Days from 1970-01-01; the day of month counts from one.
  assign days2 = 24'(yy365_2_r) + 24'(yy4_2_r) + 24'(p400_2_r[22:RECIP_SHIFT]) +
                 24'(moff2_r) + 24'(dd2_r) - 24'(p100_2_r[24:RECIP_SHIFT]) -
                 24'(EPOCH_SHIFT) - 24'd1;

  // ---------------------------------------------------------------------------
  // Stage 3: days to seconds, then the result register.
  // ---------------------------------------------------------------------------
  logic               ok3_r;
  logic signed [23:0] days3_r;
  logic [16:0]        tod3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ok3_r   <= ok2_r;
      days3_r <= signed'(days2);
      tod3_r  <= tod2_r;
    end
  end

  secs_t days_ext;
  secs_t secs3;

  assign days_ext = 39'(days3_r);
  assign secs3    = days_ext * 39'sd86400 + $signed({22'd0, tod3_r});

  logic  out_ok_r;
  secs_t out_secs_r;

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_ok_r   <= ok3_r;
      out_secs_r <= ok3_r ? secs3 : '0;
    end
  end

  assign out_m.valid         = out_v_r;
  assign out_m.valid_res     = out_ok_r;
  assign out_m.epoch_seconds = out_secs_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
`include "utc_datetime_to_epoch_seconds_core_defines.svh"

  // A last character leaves the accumulators clear for the next timestamp.
  `UTCEP_ASSERT_NEXT(a_clear_after_last, in_acc && in_s.is_last, (pos_r == 5'd0) && !bad_r, "intake state not cleared after last beat")

  // Only a last character starts a conversion.
  `UTCEP_ASSERT_SAME(a_conv_from_last, $rose(v1_r), $past(in_acc && in_s.is_last), "conversion started without a last beat")

  // A good timestamp always lands inside the four-digit year range.
  `UTCEP_ASSERT_SAME(a_secs_range, out_v_r && out_ok_r, (out_secs_r >= EPOCH_MIN) && (out_secs_r <= EPOCH_MAX), "epoch seconds out of range")

endmodule
